@@ hw/rtl/mcsd_pkg.sv @@
// Shared types and constants for the modem carrier string detector.
// Holds the two match patterns, counter widths and the result struct.
// No dependencies.
`default_nettype none

package mcsd_pkg;

  localparam int CNT_W     = 4;
  localparam int PAT_DEPTH = 1 << CNT_W;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [0:PAT_DEPTH-1][7:0] pattern_t;

  localparam count_t DROP_LEN    = count_t'(14);
  localparam count_t CONNECT_LEN = count_t'(11);

  // CR LF "NO CARRIER" CR LF, padded past its length with zeros
  localparam pattern_t DROP_PATTERN = '{
    8'h0D, 8'h0A, 8'h4E, 8'h4F, 8'h20, 8'h43, 8'h41, 8'h52,
    8'h52, 8'h49, 8'h45, 8'h52, 8'h0D, 8'h0A, 8'h00, 8'h00
  };

  // CR LF "CONNECT" CR LF, padded past its length with zeros
  localparam pattern_t CONNECT_PATTERN = '{
    8'h0D, 8'h0A, 8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43,
    8'h54, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    count_t count_next;
    logic   full;
  } match_t;

  typedef struct packed {
    logic carrier_up;
    logic connect_seen;
    logic drop_seen;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/mcsd_if.sv @@
// Handshake interfaces of the modem carrier string detector:
// received byte channel, result channel and configuration write channel.
// No dependencies.
`default_nettype none

interface mcsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mcsd_result_if;
  logic valid;
  logic ready;
  logic carrier_up;
  logic connect_seen;
  logic drop_seen;

  modport source (output valid, output carrier_up, output connect_seen, output drop_seen,
                  input ready);
  modport sink (input valid, input carrier_up, input connect_seen, input drop_seen,
                output ready);
endinterface

interface mcsd_cfg_if;
  logic valid;
  logic ready;
  logic terminal_mode;

  modport source (output valid, output terminal_mode, input ready);
  modport sink (input valid, input terminal_mode, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mcsd_matcher.sv @@
// One streaming pattern matcher step: next partial-match count and full-match flag.
// Depends on mcsd_pkg.
`default_nettype none

module mcsd_matcher (
  input  mcsd_pkg::count_t   count,
  input  logic [7:0]         rx_byte,
  input  mcsd_pkg::pattern_t pattern,
  input  mcsd_pkg::count_t   pattern_len,
  output mcsd_pkg::match_t   match
);
  import mcsd_pkg::*;

  count_t advanced;

  always_comb begin
    if (count < pattern_len && pattern[count] == rx_byte) begin
      advanced = count_t'(count + count_t'(1));
    end else if (pattern[0] == rx_byte) begin
      advanced = count_t'(1);
    end else begin
      advanced = '0;
    end
    // restart after a full match
    match.full       = (advanced == pattern_len);
    match.count_next = match.full ? '0 : advanced;
  end

endmodule

`default_nettype wire

@@ hw/rtl/modem_carrier_string_detector.sv @@
// Modem carrier string detector, top level. Depends on mcsd_pkg, mcsd_if, mcsd_matcher.
// A byte passes the input register, then the result register, before its result is valid.
// Throughput: one byte per cycle while status is ready; the carrier flag and both match
//   counters update in the same cycle the byte leaves the input register, so the next
//   byte sees them.
// Reset (rst, synchronous, active high): carrier down, counters zero, terminal mode off,
//   both pipeline registers empty.
`default_nettype none

module modem_carrier_string_detector (
  input  wire logic     clk,
  input  wire logic     rst,
  mcsd_byte_if.sink     rx,
  mcsd_cfg_if.sink      cfg,
  mcsd_result_if.source status
);
  import mcsd_pkg::*;

  // Configuration: always ready; the user must write it only while the block is idle, the block does not enforce this.
  logic terminal_mode;

  // Input register stage.
  logic       in_valid;
  logic [7:0] in_byte;

  // Detector state.
  logic   carrier_flag;
  count_t drop_count;
  count_t connect_count;

  // Result register stage.
  logic    out_valid;
  result_t out_result;

  logic    advance;
  match_t  drop_match;
  match_t  connect_match;
  logic    carrier_next;
  count_t  drop_count_next;
  count_t  connect_count_next;
  result_t result_next;
  logic    flag_mid;

  // Move the held byte into the result register whenever that register is free or drained.
  assign advance  = in_valid && (!out_valid || status.ready);
  assign rx.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  assign status.valid        = out_valid;
  assign status.carrier_up   = out_result.carrier_up;
  assign status.connect_seen = out_result.connect_seen;
  assign status.drop_seen    = out_result.drop_seen;

  // Both matchers evaluate on the current counts; selection below decides who updates.
  mcsd_matcher u_drop (
    .count       (drop_count),
    .rx_byte     (in_byte),
    .pattern     (DROP_PATTERN),
    .pattern_len (DROP_LEN),
    .match       (drop_match)
  );

  mcsd_matcher u_connect (
    .count       (connect_count),
    .rx_byte     (in_byte),
    .pattern     (CONNECT_PATTERN),
    .pattern_len (CONNECT_LEN),
    .match       (connect_match)
  );

  always_comb begin
    carrier_next       = carrier_flag;
    drop_count_next    = drop_count;
    connect_count_next = connect_count;
    result_next        = '{carrier_up: carrier_flag, connect_seen: 1'b0, drop_seen: 1'b0};
    flag_mid           = carrier_flag;
    if (!terminal_mode) begin
      // Disconnect check first: watch NO CARRIER only while connected.
      if (carrier_flag) begin
        drop_count_next = drop_match.count_next;
        if (drop_match.full) begin
          flag_mid              = 1'b0;
          result_next.drop_seen = 1'b1;
        end
      end
      // Connect check sees the flag as left by the disconnect check on this same byte.
      carrier_next = flag_mid;
      if (!flag_mid) begin
        connect_count_next = connect_match.count_next;
        if (connect_match.full) begin
          carrier_next             = 1'b1;
          result_next.connect_seen = 1'b1;
        end
      end
      result_next.carrier_up = carrier_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_mode <= 1'b0;
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      carrier_flag  <= 1'b0;
      drop_count    <= '0;
      connect_count <= '0;
    end else begin
      if (cfg.valid) begin
        terminal_mode <= cfg.terminal_mode;
      end
      // Input register: load on acceptance, drop once the byte has advanced.
      if (rx.valid && rx.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      // Result register: hold until taken, refill on advance.
      if (advance) begin
        out_valid     <= 1'b1;
        carrier_flag  <= carrier_next;
        drop_count    <= drop_count_next;
        connect_count <= connect_count_next;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
    if (advance) begin
      out_result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // A completed connect pattern always leaves the carrier up.
  a_connect_sets_carrier: assert property (@(posedge clk) disable iff (rst)
    status.valid && status.connect_seen |-> status.carrier_up)
    else $error("connect transaction without carrier up");

  // A drop not followed by a reconnect on the same byte leaves the carrier down.
  a_drop_clears_carrier: assert property (@(posedge clk) disable iff (rst)
    status.valid && status.drop_seen && !status.connect_seen |-> !status.carrier_up)
    else $error("drop transaction with carrier still up");

  // Terminal mode bytes leave the detector state untouched.
  a_terminal_holds_state: assert property (@(posedge clk) disable iff (rst)
    advance && terminal_mode |=>
      $stable(carrier_flag) && $stable(drop_count) && $stable(connect_count))
    else $error("detector state changed in terminal mode");

  // Counters never reach their pattern length.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    drop_count < DROP_LEN && connect_count < CONNECT_LEN)
    else $error("match counter out of range");
`endif

endmodule

`default_nettype wire

@@ tb/carrier_check_pkg.sv @@
// Scoreboard package for the modem carrier string detector testbench:
// byte patterns, the expected status record and the predicting scoreboard class.
// No dependencies on the RTL.
package carrier_check_pkg;

  typedef logic [0:15][7:0] byte_seq_t;

  // CR LF "CONNECT" CR LF
  localparam byte_seq_t CONNECT_SEQ = {
    8'h0D, 8'h0A, 8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43,
    8'h54, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam int CONNECT_SEQ_LEN = 11;

  // CR LF "NO CARRIER" CR LF
  localparam byte_seq_t NO_CARRIER_SEQ = {
    8'h0D, 8'h0A, 8'h4E, 8'h4F, 8'h20, 8'h43, 8'h41, 8'h52,
    8'h52, 8'h49, 8'h45, 8'h52, 8'h0D, 8'h0A, 8'h00, 8'h00
  };
  localparam int NO_CARRIER_SEQ_LEN = 14;

  typedef struct packed {
    logic carrier_up;
    logic connect_seen;
    logic drop_seen;
  } carrier_status_t;

  class carrier_scoreboard;
    bit              terminal_mode;
    bit              carrier;
    logic [3:0]      drop_cnt;
    logic [3:0]      connect_cnt;
    carrier_status_t expected_status[$];
    int unsigned     errors;

    function new();
      terminal_mode = 1'b0;
      carrier       = 1'b0;
      drop_cnt      = '0;
      connect_cnt   = '0;
      errors        = 0;
    endfunction

    // Advance one matcher by one byte; return 1 on a full match and clear the count.
    function bit advance_match(input byte_seq_t pat, input int len,
                               inout logic [3:0] cnt, input logic [7:0] b);
      int nxt;
      if (int'(cnt) < len && pat[cnt] == b) nxt = int'(cnt) + 1;
      else if (pat[0] == b) nxt = 1;
      else nxt = 0;
      if (nxt == len) begin
        cnt = '0;
        return 1'b1;
      end
      cnt = nxt[3:0];
      return 1'b0;
    endfunction

    function void set_terminal_mode(input bit m);
      terminal_mode = m;
    endfunction

    // Predict the status for an accepted byte and queue it.
    function void predict_byte(input logic [7:0] b);
      carrier_status_t s;
      s = '0;
      if (!terminal_mode) begin
        if (carrier && advance_match(NO_CARRIER_SEQ, NO_CARRIER_SEQ_LEN, drop_cnt, b)) begin
          carrier     = 1'b0;
          s.drop_seen = 1'b1;
        end
        if (!carrier && advance_match(CONNECT_SEQ, CONNECT_SEQ_LEN, connect_cnt, b)) begin
          carrier        = 1'b1;
          s.connect_seen = 1'b1;
        end
      end
      s.carrier_up = carrier;
      expected_status.push_back(s);
    endfunction

    function void check_status(input carrier_status_t got);
      carrier_status_t want;
      if (expected_status.size() == 0) begin
        $error("status with no byte pending: carrier_up=%0b connect_seen=%0b drop_seen=%0b",
               got.carrier_up, got.connect_seen, got.drop_seen);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      if (got.carrier_up !== want.carrier_up) begin
        $error("carrier_up: expected %0b, got %0b", want.carrier_up, got.carrier_up);
        errors++;
      end
      if (got.connect_seen !== want.connect_seen) begin
        $error("connect_seen: expected %0b, got %0b", want.connect_seen, got.connect_seen);
        errors++;
      end
      if (got.drop_seen !== want.drop_seen) begin
        $error("drop_seen: expected %0b, got %0b", want.drop_seen, got.drop_seen);
        errors++;
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

endpackage

@@ tb/tb_modem_carrier_string_detector.sv @@
// Top-level testbench for modem_carrier_string_detector: drives received bytes and
// terminal-mode writes, predicts each status transaction and checks it in order.
// Depends on mcsd_if (RTL interfaces), carrier_check_pkg and the block itself.
module tb_modem_carrier_string_detector;
  import carrier_check_pkg::*;

  localparam int CYCLE_LIMIT   = 60000;
  localparam int DRAIN_CYCLES  = 8;    // extra wait after the last pending status
  localparam int LONG_HOLD     = 300;  // receiver hold-off, in cycles
  localparam int IDLE_PCT      = 12;
  localparam int PART1_BYTES   = 830;
  localparam int PART2_BYTES   = 780;
  localparam int TERM_BYTES    = 100;
  localparam int STEADY_BYTES  = 300;  // opening stretch of part 1 with no idling
  localparam int HOLD_AT_BYTE  = 500;  // where part 1 asks for the long hold-off
  localparam bit MODE_DETECT   = 1'b0;
  localparam bit MODE_TERMINAL = 1'b1;
  localparam logic [7:0] CR    = 8'h0D;
  localparam logic [7:0] LF    = 8'h0A;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcsd_byte_if   rx_if ();
  mcsd_cfg_if    cfg_if ();
  mcsd_result_if res_if ();

  modem_carrier_string_detector dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .cfg    (cfg_if),
    .status (res_if)
  );

  carrier_scoreboard sb = new();

  // Testbench state; steady and hold_requests are shared by the byte sender and the status receiver.
  bit steady        = 1'b0;  // suppress random idling on both sides
  int hold_requests = 0;     // bumped by the sender, served by the receiver
  bit cur_mode      = MODE_DETECT;
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_modem_carrier_string_detector: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Status receiver. Drive ready at the falling edge, sample at the rising edge.
  // A hold request from the sender turns into a long stretch of ready low,
  // counted here, so the pipeline fills and back-pressures the byte channel.
  // ---------------------------------------------------------------------------
  initial begin : status_sink
    int hold_served;
    int hold_left;
    carrier_status_t got;
    hold_served = 0;
    hold_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got.carrier_up   = res_if.carrier_up;
        got.connect_seen = res_if.connect_seen;
        got.drop_seen    = res_if.drop_seen;
        sb.check_status(got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte sender tasks.
  // ---------------------------------------------------------------------------

  // Offer one byte, with random idle cycles ahead of it, and hold it until the
  // transaction completes. Valid stays high into the next byte when no idle follows.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    sb.predict_byte(b);
  endtask

  // Send the first 'stop' bytes of a pattern; replace byte 'bad_pos' with noise
  // (a negative position keeps the pattern intact).
  task automatic send_pattern(input bit drop_side, input int stop, input int bad_pos);
    logic [7:0] b;
    for (int i = 0; i < stop; i++) begin
      b = drop_side ? NO_CARRIER_SEQ[i] : CONNECT_SEQ[i];
      if (i == bad_pos) b = 8'($urandom_range(255));
      send_byte(b);
    end
  endtask

  // Drop the byte channel, let every pending status drain, then write
  // terminal_mode with the block idle.
  task automatic write_mode(input bit m);
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.terminal_mode <= m;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_terminal_mode(m);
    cur_mode = m;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // One random chunk of traffic; most chunks are whole or nearly whole
  // patterns, so the matchers get deep, the rest is noise and line breaks.
  task automatic send_chunk(output int n);
    int  pick;
    int  len;
    bit  watched;
    pick    = $urandom_range(99);
    watched = sb.carrier;  // 1: the no-carrier pattern is being tracked
    if (pick < 30) begin
      len = watched ? NO_CARRIER_SEQ_LEN : CONNECT_SEQ_LEN;
      send_pattern(watched, len, -1);
      n = len;
    end else if (pick < 40) begin
      len = watched ? CONNECT_SEQ_LEN : NO_CARRIER_SEQ_LEN;
      send_pattern(!watched, len, -1);
      n = len;
    end else if (pick < 60) begin
      // truncated pattern, then a CR or a random byte
      len = $urandom_range(watched ? NO_CARRIER_SEQ_LEN - 1 : CONNECT_SEQ_LEN - 1, 1);
      send_pattern(watched, len, -1);
      send_byte($urandom_range(1) ? CR : 8'($urandom_range(255)));
      n = len + 1;
    end else if (pick < 75) begin
      // whole pattern with one byte corrupted
      len = watched ? NO_CARRIER_SEQ_LEN : CONNECT_SEQ_LEN;
      send_pattern(watched, len, $urandom_range(len - 1));
      n = len;
    end else if (pick < 87) begin
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++) send_byte($urandom_range(1) ? CR : LF);
      n = len;
    end else begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
      n = len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int sent;
    int n;
    bit hold_asked;
    rx_if.valid          = 1'b0;
    rx_if.rx_byte        = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.terminal_mode = MODE_DETECT;

    // Hold reset, then release it at a falling edge.
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, a clean connect, then a no-carrier split by a
    // terminal-mode stretch that must leave the partial match untouched.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_pattern(1'b0, CONNECT_SEQ_LEN, -1);
    for (int i = 0; i < 4; i++) send_byte(NO_CARRIER_SEQ[i]);
    write_mode(MODE_TERMINAL);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CR);
    send_byte(8'h41);
    write_mode(MODE_DETECT);
    for (int i = 4; i < NO_CARRIER_SEQ_LEN; i++) send_byte(NO_CARRIER_SEQ[i]);

    // Random part 1: opens with no idling, then asks for one long hold-off.
    sent       = 0;
    hold_asked = 1'b0;
    steady     = 1'b1;
    while (sent < PART1_BYTES) begin
      if (sent >= STEADY_BYTES) steady = 1'b0;
      if (!hold_asked && sent >= HOLD_AT_BYTE) begin
        hold_requests++;
        hold_asked = 1'b1;
      end
      send_chunk(n);
      sent += n;
    end
    steady = 1'b0;

    // Terminal mode mid-stream: bytes pass through, matcher state frozen.
    write_mode(MODE_TERMINAL);
    sent = 0;
    while (sent < TERM_BYTES) begin
      send_chunk(n);
      sent += n;
    end
    write_mode(MODE_DETECT);

    // Random part 2.
    sent = 0;
    while (sent < PART2_BYTES) begin
      send_chunk(n);
      sent += n;
    end

    // Drain: drop valid, wait for every status, then a few more cycles.
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_modem_carrier_string_detector: clean");
    end else begin
      $display("tb_modem_carrier_string_detector: errors");
    end
    $finish;
  end

endmodule
